>>> rtl/tsdf_pkg.sv
// Shared types and constants for the text stream display formatter.
// No dependencies; every module of the block imports this package.

package tsdf_pkg;

   // Width of the decimal line counter
   localparam int COUNT_DIGITS = 6;

   // Output slots for one input word:
   // the number digits, the tab after the number, '$', the caret of a shown tab,
   // 'M', '-', the control caret, and the final character.
   localparam int SLOT_TAB    = COUNT_DIGITS;
   localparam int SLOT_DOLLAR = COUNT_DIGITS + 1;
   localparam int SLOT_TCARET = COUNT_DIGITS + 2;
   localparam int SLOT_M      = COUNT_DIGITS + 3;
   localparam int SLOT_DASH   = COUNT_DIGITS + 4;
   localparam int SLOT_CARET  = COUNT_DIGITS + 5;
   localparam int SLOT_FINAL  = COUNT_DIGITS + 6;
   localparam int NUM_SLOTS   = COUNT_DIGITS + 7;

   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_DOLLAR = 8'd36;
   localparam logic [7:0] CH_CARET  = 8'd94;
   localparam logic [7:0] CH_M      = 8'd77;
   localparam logic [7:0] CH_DASH   = 8'd45;
   localparam logic [7:0] CH_QMARK  = 8'd63;
   localparam logic [7:0] CH_DEL    = 8'd127;
   localparam logic [7:0] CH_CTRL_OFS = 8'd64;
   localparam logic [7:0] CH_HIGH_OFS = 8'd128;
   localparam logic [7:0] CH_CTRL_END = 8'd32;

   typedef enum logic [2:0] {
      CSR_NUMBER_MODE      = 3'd0,
      CSR_SQUEEZE_BLANK    = 3'd1,
      CSR_SHOW_ENDS        = 3'd2,
      CSR_SHOW_TABS        = 3'd3,
      CSR_SHOW_NONPRINTING = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      NUM_OFF      = 2'd0,
      NUM_ALL      = 2'd1,
      NUM_NONBLANK = 2'd2
   } num_mode_type;

   typedef struct packed {
      logic [1:0] number_mode;
      logic       squeeze_blank;
      logic       show_ends;
      logic       show_tabs;
      logic       show_nonprinting;
   } cfg_type;

   // Everything the emitter needs to play out one input word
   typedef struct packed {
      logic [NUM_SLOTS-1:0]              slot_mask;
      logic [COUNT_DIGITS-1:0][7:0]      num_chars;   // index 0 is least significant
      logic [7:0]                        final_char;
   } job_type;

endpackage

>>> rtl/tsdf_csr.sv
// Configuration registers of the display formatter.
// Depends on tsdf_pkg for the register index codes and cfg_type.

module tsdf_csr
   import tsdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [1:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUMBER_MODE:      cfg_in.number_mode      = csr_wdata;
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_wdata[0];
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_wdata[0];
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_wdata[0];
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/tsdf_decode.sv
// Front end: newline history, BCD line counter and the slot plan for one word.
// Depends on tsdf_pkg for cfg_type, job_type and character constants.

module tsdf_decode
   import tsdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       accept,
   input  logic [7:0] in_byte,
   output logic       keep,
   output job_type    job
);

   logic                          prev_nl_ff, prev_nl_in;
   logic                          prev2_nl_ff, prev2_nl_in;
   logic [COUNT_DIGITS-1:0][3:0]  digits_ff, digits_in;

   logic                          is_nl;
   logic                          do_num;
   logic                          all_nine;
   logic                          carry;
   logic                          started;
   logic [COUNT_DIGITS-1:0][3:0]  bumped;
   logic [COUNT_DIGITS-1:0][7:0]  num_chars;
   logic                          tab_caret;
   logic                          nonprint;
   logic                          high_bit;
   logic                          ctrl_caret;
   logic [7:0]                    c1;
   logic [7:0]                    c2;

   assign is_nl = (in_byte == CH_NL);
   assign keep  = !(cfg.squeeze_blank && prev2_nl_ff && prev_nl_ff && is_nl);
   assign do_num = prev_nl_ff &&
                   ((cfg.number_mode == NUM_ALL) ||
                    ((cfg.number_mode == NUM_NONBLANK) && !is_nl));

   // Increment with saturation at all nines
   always_comb begin
      all_nine = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (digits_ff[i] != 4'd9) all_nine = 1'b0;
      end
      bumped = digits_ff;
      carry  = !all_nine;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (carry) begin
            if (digits_ff[i] >= 4'd9) begin
               bumped[i] = 4'd0;
            end else begin
               bumped[i] = digits_ff[i] + 4'd1;
               carry     = 1'b0;
            end
         end
      end
   end

   // Leading zeros print as spaces; the units digit always prints
   always_comb begin
      started = 1'b0;
      num_chars = '0;
      for (int i = COUNT_DIGITS - 1; i >= 0; i--) begin
         if (bumped[i] != 4'd0 || i == 0) started = 1'b1;
         num_chars[i] = started ? (CH_ZERO + {4'd0, bumped[i]}) : CH_SPACE;
      end
   end

   always_comb begin
      job.num_chars = num_chars;
      tab_caret  = cfg.show_tabs && (in_byte == CH_TAB);
      c1         = tab_caret ? (in_byte + CH_CTRL_OFS) : in_byte;
      nonprint   = cfg.show_nonprinting &&
                   (((c1 < CH_CTRL_END) && (c1 != CH_NL) && (c1 != CH_TAB)) ||
                    (c1 >= CH_DEL));
      high_bit   = nonprint && c1[7];
      c2         = high_bit ? (c1 - CH_HIGH_OFS) : c1;
      ctrl_caret = nonprint && ((c2 < CH_CTRL_END) || (c2 == CH_DEL));
      if (!ctrl_caret) begin
         job.final_char = c2;
      end else if (c2 == CH_DEL) begin
         job.final_char = CH_QMARK;
      end else begin
         job.final_char = c2 + CH_CTRL_OFS;
      end

      job.slot_mask = '0;
      job.slot_mask[COUNT_DIGITS-1:0] = {COUNT_DIGITS{do_num}};
      job.slot_mask[SLOT_TAB]    = do_num;
      job.slot_mask[SLOT_DOLLAR] = cfg.show_ends && is_nl;
      job.slot_mask[SLOT_TCARET] = tab_caret;
      job.slot_mask[SLOT_M]      = high_bit;
      job.slot_mask[SLOT_DASH]   = high_bit;
      job.slot_mask[SLOT_CARET]  = ctrl_caret;
      job.slot_mask[SLOT_FINAL]  = 1'b1;
   end

   always_comb begin
      prev_nl_in  = prev_nl_ff;
      prev2_nl_in = prev2_nl_ff;
      digits_in   = digits_ff;
      if (accept && keep) begin
         prev2_nl_in = prev_nl_ff;
         prev_nl_in  = is_nl;
         if (do_num) digits_in = bumped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_nl_ff  <= 1'b1;
         prev2_nl_ff <= 1'b0;
         digits_ff   <= '0;
      end else begin
         prev_nl_ff  <= prev_nl_in;
         prev2_nl_ff <= prev2_nl_in;
         digits_ff   <= digits_in;
      end
   end

endmodule

>>> rtl/tsdf_emit.sv
// Job register and result register: plays out the active slots of one word,
// lowest slot first. Depends on tsdf_pkg for job_type and slot constants.

module tsdf_emit
   import tsdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  job_type    job,
   input  logic       rsp_stall,
   output logic       busy,
   output logic       finishing,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic [NUM_SLOTS-1:0]          mask_ff, mask_in;
   logic [COUNT_DIGITS-1:0][7:0]  num_ff;
   logic [7:0]                    final_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_byte_ff, rsp_byte_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          emit;
   logic [NUM_SLOTS-1:0]          low_slot;
   logic [NUM_SLOTS-1:0]          rest;
   logic [NUM_SLOTS-1:0][7:0]     slot_char;
   logic [7:0]                    sel_char;

   assign busy     = |mask_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = busy && out_free;
   assign low_slot = mask_ff & (~mask_ff + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
   assign rest     = mask_ff & ~low_slot;
   assign finishing = emit && (rest == '0);

   always_comb begin
      for (int k = 0; k < COUNT_DIGITS; k++) begin
         slot_char[k] = num_ff[COUNT_DIGITS-1-k];   // most significant digit first
      end
      slot_char[SLOT_TAB]    = CH_TAB;
      slot_char[SLOT_DOLLAR] = CH_DOLLAR;
      slot_char[SLOT_TCARET] = CH_CARET;
      slot_char[SLOT_M]      = CH_M;
      slot_char[SLOT_DASH]   = CH_DASH;
      slot_char[SLOT_CARET]  = CH_CARET;
      slot_char[SLOT_FINAL]  = final_ff;
      sel_char = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         sel_char = sel_char | (slot_char[k] & {8{low_slot[k]}});
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = job.slot_mask;
      end else if (emit) begin
         mask_in = rest;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = sel_char;
         rsp_last_in  = (rest == '0);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff   <= job.num_chars;
         final_ff <= job.final_char;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

>>> rtl/text_stream_display_formatter_core.sv
// Top level of the text stream display formatter (cat-style numbering and
// nonprinting display). Depends on tsdf_pkg, tsdf_csr, tsdf_decode, tsdf_emit.
//
//   channel   ports                                   direction
//   req       req_valid req_stall req_in_byte         in word, one raw text byte
//   rsp       rsp_valid rsp_stall rsp_out_byte
//             rsp_last_of_run                          out word, one display byte
//   csr       csr_we csr_index csr_wdata              register writes
//
// Each input word yields 0 to 11 output words, one per cycle from the job register
// unless rsp stalls; a plain byte gives one word, a numbered line start adds seven.
// The next input word is taken in the cycle the last word of the current one
// moves into the result register. A squeezed newline is taken and gives nothing.
// Sync reset clears cfg, job mask, rsp_valid and line count; history starts a new line.
// A stall on rsp holds the result register and the job, and req while a job is loaded.

module text_stream_display_formatter_core
   import tsdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [1:0] csr_wdata
);

   cfg_type cfg;
   job_type job;
   logic    keep;
   logic    busy;
   logic    finishing;
   logic    req_accept;
   logic    job_load;

   assign req_stall  = busy && !finishing;
   assign req_accept = req_valid && !req_stall;
   assign job_load   = req_accept && keep;

   tsdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tsdf_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (req_accept),
      .in_byte (req_in_byte),
      .keep    (keep),
      .job     (job)
   );

   tsdf_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (job_load),
      .job             (job),
      .rsp_stall       (rsp_stall),
      .busy            (busy),
      .finishing       (finishing),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // A kept word always leaves work in the job register
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      job_load |=> busy)
      else $error("kept word left no job");

   // Input is only held back while a job still has words after this cycle
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !req_stall)
      else $error("input stalled with no job");

   // Nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
